// ===== hdl/pet_pkg.sv =====
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types, register indexes and fixed-point helpers for the pose
// extrinsic transform.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int DataW = 32;
  localparam int IndexW = 3;

  // register indexes on the configuration port
  localparam logic [IndexW-1:0] REG_OFFSET_X     = 3'd0;
  localparam logic [IndexW-1:0] REG_OFFSET_Y     = 3'd1;
  localparam logic [IndexW-1:0] REG_OFFSET_Z     = 3'd2;
  localparam logic [IndexW-1:0] REG_ROT_COS_HALF = 3'd3;
  localparam logic [IndexW-1:0] REG_ROT_SIN_HALF = 3'd4;
  localparam logic [IndexW-1:0] REG_DIRECTION    = 3'd5;

  // direction codes
  localparam logic DIR_INVERSE = 1'b0;
  localparam logic DIR_FORWARD = 1'b1;

  localparam logic signed [34:0] QOne    = 35'sd1073741824;
  localparam logic signed [34:0] QNegOne = -35'sd1073741824;
  localparam logic signed [41:0] PosMax  = 42'sd2147483647;
  localparam logic signed [41:0] PosMin  = -42'sd2147483648;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_quat_w;
    logic signed [31:0] out_quat_x;
    logic signed [31:0] out_quat_y;
    logic signed [31:0] out_quat_z;
  } pose_out_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  // unsaturated rotated vector, Q15.16 with headroom
  typedef struct packed {
    logic signed [40:0] x;
    logic signed [40:0] y;
    logic signed [40:0] z;
  } rvec_t;

  function automatic logic signed [31:0] clamp_q(input logic signed [34:0] v);
    logic signed [31:0] res;
    if (v > QOne) begin
      res = QOne[31:0];
    end else if (v < QNegOne) begin
      res = QNegOne[31:0];
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [41:0] v);
    logic signed [31:0] res;
    if (v > PosMax) begin
      res = PosMax[31:0];
    end else if (v < PosMin) begin
      res = PosMin[31:0];
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/pet_quat_mul.sv =====
// ----------------------------------------------------------------------------
// pet_quat_mul
// Two-stage product of the z-only extrinsic quaternion with the pose
// quaternion, conjugated or not, rounded to Q1.30 and clamped.
// ----------------------------------------------------------------------------
module pet_quat_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pet_pkg::quat_t      q,
  input  logic signed [31:0]  c,
  input  logic signed [31:0]  s,
  input  logic                dir,
  output logic                out_valid,
  output pet_pkg::quat_t      nq
);

  localparam logic signed [64:0] Half = 65'sd536870912;

  logic               prod_valid;
  logic signed [63:0] cw, cx, cy, cz, sw, sx, sy, sz;
  logic signed [64:0] sum_w, sum_x, sum_y, sum_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    cw <= c * $signed(q.w);
    cx <= c * $signed(q.x);
    cy <= c * $signed(q.y);
    cz <= c * $signed(q.z);
    sw <= s * $signed(q.w);
    sx <= s * $signed(q.x);
    sy <= s * $signed(q.y);
    sz <= s * $signed(q.z);
  end

  // inverse uses conj(e), forward uses e: only the sign of the sine terms flips
  always_comb begin
    if (dir == pet_pkg::DIR_FORWARD) begin
      sum_w = {cw[63], cw} - {sz[63], sz} + Half;
      sum_x = {cx[63], cx} - {sy[63], sy} + Half;
      sum_y = {cy[63], cy} + {sx[63], sx} + Half;
      sum_z = {cz[63], cz} + {sw[63], sw} + Half;
    end else begin
      sum_w = {cw[63], cw} + {sz[63], sz} + Half;
      sum_x = {cx[63], cx} + {sy[63], sy} + Half;
      sum_y = {cy[63], cy} - {sx[63], sx} + Half;
      sum_z = {cz[63], cz} - {sw[63], sw} + Half;
    end
  end

  always_ff @(posedge clk) begin
    nq.w <= pet_pkg::clamp_q(sum_w[64:30]);
    nq.x <= pet_pkg::clamp_q(sum_x[64:30]);
    nq.y <= pet_pkg::clamp_q(sum_y[64:30]);
    nq.z <= pet_pkg::clamp_q(sum_z[64:30]);
  end

endmodule

// ===== hdl/pet_rotate.sv =====
// ----------------------------------------------------------------------------
// pet_rotate
// Four-stage rotation of a vector by an unnormalized quaternion:
// v + 2w(u x v) + 2u x (u x v), with the cross product rounded once.
// ----------------------------------------------------------------------------
module pet_rotate (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  pet_pkg::quat_t  u,
  input  pet_pkg::vec_t   v,
  output logic            out_valid,
  output pet_pkg::rvec_t  r
);

  localparam logic signed [64:0] HalfA = 65'sd536870912;
  localparam logic signed [66:0] HalfB = 67'sd268435456;

  logic valid_a, valid_b, valid_c;

  // stage a: cross product terms
  logic signed [63:0]  m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
  pet_pkg::quat_t      u_a, u_b;
  pet_pkg::vec_t       v_a, v_b, v_c;
  // stage b: rounded cross product
  logic signed [64:0]  d0, d1, d2;
  logic signed [34:0]  a0, a1, a2;
  // stage c: second products
  logic signed [66:0]  wa0, wa1, wa2, pa0, pb0, pa1, pb1, pa2, pb2;
  // stage d: rounding and sum
  logic signed [37:0]  t_wa0, t_wa1, t_wa2;
  logic signed [37:0]  t_pa0, t_pb0, t_pa1, t_pb1, t_pa2, t_pb2;
  logic signed [66:0]  h_wa0, h_wa1, h_wa2, h_pa0, h_pb0, h_pa1, h_pb1, h_pa2, h_pb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      valid_c   <= valid_b;
      out_valid <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    m_yz <= $signed(u.y) * $signed(v.z);
    m_zy <= $signed(u.z) * $signed(v.y);
    m_zx <= $signed(u.z) * $signed(v.x);
    m_xz <= $signed(u.x) * $signed(v.z);
    m_xy <= $signed(u.x) * $signed(v.y);
    m_yx <= $signed(u.y) * $signed(v.x);
    u_a  <= u;
    v_a  <= v;
  end

  always_comb begin
    d0 = {m_yz[63], m_yz} - {m_zy[63], m_zy} + HalfA;
    d1 = {m_zx[63], m_zx} - {m_xz[63], m_xz} + HalfA;
    d2 = {m_xy[63], m_xy} - {m_yx[63], m_yx} + HalfA;
  end

  always_ff @(posedge clk) begin
    a0  <= d0[64:30];
    a1  <= d1[64:30];
    a2  <= d2[64:30];
    u_b <= u_a;
    v_b <= v_a;
  end

  always_ff @(posedge clk) begin
    wa0 <= $signed(u_b.w) * a0;
    wa1 <= $signed(u_b.w) * a1;
    wa2 <= $signed(u_b.w) * a2;
    pa0 <= $signed(u_b.y) * a2;
    pb0 <= $signed(u_b.z) * a1;
    pa1 <= $signed(u_b.z) * a0;
    pb1 <= $signed(u_b.x) * a2;
    pa2 <= $signed(u_b.x) * a1;
    pb2 <= $signed(u_b.y) * a0;
    v_c <= v_b;
  end

  // each term rounded to Q15.16 with the factor two folded into the shift
  always_comb begin
    h_wa0 = wa0 + HalfB;
    h_wa1 = wa1 + HalfB;
    h_wa2 = wa2 + HalfB;
    h_pa0 = pa0 + HalfB;
    h_pb0 = pb0 + HalfB;
    h_pa1 = pa1 + HalfB;
    h_pb1 = pb1 + HalfB;
    h_pa2 = pa2 + HalfB;
    h_pb2 = pb2 + HalfB;
    t_wa0 = h_wa0[66:29];
    t_wa1 = h_wa1[66:29];
    t_wa2 = h_wa2[66:29];
    t_pa0 = h_pa0[66:29];
    t_pb0 = h_pb0[66:29];
    t_pa1 = h_pa1[66:29];
    t_pb1 = h_pb1[66:29];
    t_pa2 = h_pa2[66:29];
    t_pb2 = h_pb2[66:29];
  end

  always_ff @(posedge clk) begin
    r.x <= 41'(v_c.x) + 41'(t_wa0) + 41'(t_pa0) - 41'(t_pb0);
    r.y <= 41'(v_c.y) + 41'(t_wa1) + 41'(t_pa1) - 41'(t_pb1);
    r.z <= 41'(v_c.z) + 41'(t_wa2) + 41'(t_pa2) - 41'(t_pb2);
  end

endmodule

// ===== hdl/pose_extrinsic_transform.sv =====
// ----------------------------------------------------------------------------
// pose_extrinsic_transform
// done follows the taken start beat through valid0, pet_quat_mul, pet_rotate and the done register
// throughput: one pose per cycle, busy stays low; the 8-stage multiply
// pipeline has no feedback and the receiver cannot stall
// reset: synchronous, clears valid bits and loads identity extrinsic
// (zero offset, cos 1.0, sin 0, inverse direction)
// ----------------------------------------------------------------------------
module pose_extrinsic_transform (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  pet_pkg::pose_in_t          pose_in,
  output logic                       done,
  output pet_pkg::pose_out_t         result,
  input  logic                       cfg_we,
  input  logic [pet_pkg::IndexW-1:0] cfg_index,
  input  logic [pet_pkg::DataW-1:0]  cfg_data
);

  localparam int PosDepth = 7;
  localparam int QuatDepth = 4;

  logic signed [31:0] offset_x, offset_y, offset_z;
  logic signed [31:0] rot_cos_half, rot_sin_half;
  logic               direction;
  logic signed [31:0] c_clamped, s_clamped;

  logic               valid0;
  pet_pkg::quat_t     q0, q1, q2;
  pet_pkg::vec_t      pos_pipe [PosDepth];
  pet_pkg::quat_t     nq_pipe [QuatDepth];

  logic               nq_valid;
  pet_pkg::quat_t     nq;
  pet_pkg::quat_t     rot_u;
  pet_pkg::vec_t      offset_v;
  logic               r_valid;
  pet_pkg::rvec_t     r;
  logic signed [41:0] px, py, pz;

  // the pipeline takes a beat every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x     <= '0;
      offset_y     <= '0;
      offset_z     <= '0;
      rot_cos_half <= pet_pkg::QOne[31:0];
      rot_sin_half <= '0;
      direction    <= pet_pkg::DIR_INVERSE;
    end else if (cfg_we) begin
      case (cfg_index)
        pet_pkg::REG_OFFSET_X:     offset_x     <= cfg_data;
        pet_pkg::REG_OFFSET_Y:     offset_y     <= cfg_data;
        pet_pkg::REG_OFFSET_Z:     offset_z     <= cfg_data;
        pet_pkg::REG_ROT_COS_HALF: rot_cos_half <= cfg_data;
        pet_pkg::REG_ROT_SIN_HALF: rot_sin_half <= cfg_data;
        pet_pkg::REG_DIRECTION:    direction    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign c_clamped = pet_pkg::clamp_q(35'(rot_cos_half));
  assign s_clamped = pet_pkg::clamp_q(35'(rot_sin_half));

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else begin
      valid0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    q0.w <= pet_pkg::clamp_q(35'(pose_in.quat_w));
    q0.x <= pet_pkg::clamp_q(35'(pose_in.quat_x));
    q0.y <= pet_pkg::clamp_q(35'(pose_in.quat_y));
    q0.z <= pet_pkg::clamp_q(35'(pose_in.quat_z));
    pos_pipe[0] <= '{x: pose_in.pos_x, y: pose_in.pos_y, z: pose_in.pos_z};
    for (int i = 1; i < PosDepth; i++) begin
      pos_pipe[i] <= pos_pipe[i-1];
    end
    q1 <= q0;
    q2 <= q1;
  end

  pet_quat_mul u_quat_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid0),
    .q         (q0),
    .c         (c_clamped),
    .s         (s_clamped),
    .dir       (direction),
    .out_valid (nq_valid),
    .nq        (nq)
  );

  // forward rotates the offset by the input attitude, inverse by the new one
  assign rot_u = (direction == pet_pkg::DIR_FORWARD) ? q2 : nq;
  assign offset_v = '{x: offset_x, y: offset_y, z: offset_z};

  always_ff @(posedge clk) begin
    nq_pipe[0] <= nq;
    for (int i = 1; i < QuatDepth; i++) begin
      nq_pipe[i] <= nq_pipe[i-1];
    end
  end

  pet_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nq_valid),
    .u         (rot_u),
    .v         (offset_v),
    .out_valid (r_valid),
    .r         (r)
  );

  always_comb begin
    if (direction == pet_pkg::DIR_FORWARD) begin
      px = 42'(pos_pipe[PosDepth-1].x) + 42'(r.x);
      py = 42'(pos_pipe[PosDepth-1].y) + 42'(r.y);
      pz = 42'(pos_pipe[PosDepth-1].z) + 42'(r.z);
    end else begin
      px = 42'(pos_pipe[PosDepth-1].x) - 42'(r.x);
      py = 42'(pos_pipe[PosDepth-1].y) - 42'(r.y);
      pz = 42'(pos_pipe[PosDepth-1].z) - 42'(r.z);
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.out_pos_x  <= pet_pkg::sat_pos(px);
    result.out_pos_y  <= pet_pkg::sat_pos(py);
    result.out_pos_z  <= pet_pkg::sat_pos(pz);
    result.out_quat_w <= nq_pipe[QuatDepth-1].w;
    result.out_quat_x <= nq_pipe[QuatDepth-1].x;
    result.out_quat_y <= nq_pipe[QuatDepth-1].y;
    result.out_quat_z <= nq_pipe[QuatDepth-1].z;
  end

endmodule

// ===== test/pose_extrinsic_transform_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_extrinsic_transform_tb
// Drives poses through the extrinsic transform under several extrinsic
// settings and sender gap rates; every output pose is checked field by field
// against a fixed-point predictor kept inside this bench.
// ----------------------------------------------------------------------------
module pose_extrinsic_transform_tb;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  pet_pkg::pose_in_t          pose_in;
  logic                       done;
  pet_pkg::pose_out_t         result;
  logic                       cfg_we;
  logic [pet_pkg::IndexW-1:0] cfg_index;
  logic [pet_pkg::DataW-1:0]  cfg_data;

  // predictor copy of the extrinsic registers
  longint ext_off_x, ext_off_y, ext_off_z, ext_cos, ext_sin;
  logic   ext_dir;

  pet_pkg::pose_out_t pending_poses[$];
  int        idle_pct;
  int        poses_sent;
  int        poses_checked;
  int        mismatches;
  int        reg_writes;

  string field_name [7] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_quat_w",
                            "out_quat_x", "out_quat_y", "out_quat_z"};

  pose_extrinsic_transform u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pose_in   (pose_in),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint round_half_up(input longint x, input int sh);
    return (x + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint limit_unit(input longint v);
    longint one;
    one = longint'(1) <<< 30;
    if (v > one) begin
      return one;
    end else if (v < -one) begin
      return -one;
    end
    return v;
  endfunction

  function automatic logic [31:0] limit_pos(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // expected output pose for one input under the current extrinsic
  function automatic pet_pkg::pose_out_t predict_pose(input pet_pkg::pose_in_t p);
    longint c, s, qw, qx, qy, qz, nw, nx, ny, nz, uw, ux, uy, uz;
    longint ax, ay, az, rx, ry, rz;
    pet_pkg::pose_out_t o;
    c  = limit_unit(ext_cos);
    s  = limit_unit(ext_sin);
    qw = limit_unit(longint'(p.quat_w));
    qx = limit_unit(longint'(p.quat_x));
    qy = limit_unit(longint'(p.quat_y));
    qz = limit_unit(longint'(p.quat_z));
    if (ext_dir == pet_pkg::DIR_FORWARD) begin
      nw = limit_unit(round_half_up(c * qw - s * qz, 30));
      nx = limit_unit(round_half_up(c * qx - s * qy, 30));
      ny = limit_unit(round_half_up(c * qy + s * qx, 30));
      nz = limit_unit(round_half_up(c * qz + s * qw, 30));
      uw = qw; ux = qx; uy = qy; uz = qz;
    end else begin
      nw = limit_unit(round_half_up(c * qw + s * qz, 30));
      nx = limit_unit(round_half_up(c * qx + s * qy, 30));
      ny = limit_unit(round_half_up(c * qy - s * qx, 30));
      nz = limit_unit(round_half_up(c * qz - s * qw, 30));
      uw = nw; ux = nx; uy = ny; uz = nz;
    end
    // offset rotated by (uw, u): v + 2w(u x v) + 2u x (u x v)
    ax = round_half_up(uy * ext_off_z - uz * ext_off_y, 30);
    ay = round_half_up(uz * ext_off_x - ux * ext_off_z, 30);
    az = round_half_up(ux * ext_off_y - uy * ext_off_x, 30);
    rx = ext_off_x + round_half_up(uw * ax, 29) + round_half_up(uy * az, 29)
         - round_half_up(uz * ay, 29);
    ry = ext_off_y + round_half_up(uw * ay, 29) + round_half_up(uz * ax, 29)
         - round_half_up(ux * az, 29);
    rz = ext_off_z + round_half_up(uw * az, 29) + round_half_up(ux * ay, 29)
         - round_half_up(uy * ax, 29);
    if (ext_dir == pet_pkg::DIR_FORWARD) begin
      o.out_pos_x = limit_pos(longint'(p.pos_x) + rx);
      o.out_pos_y = limit_pos(longint'(p.pos_y) + ry);
      o.out_pos_z = limit_pos(longint'(p.pos_z) + rz);
    end else begin
      o.out_pos_x = limit_pos(longint'(p.pos_x) - rx);
      o.out_pos_y = limit_pos(longint'(p.pos_y) - ry);
      o.out_pos_z = limit_pos(longint'(p.pos_z) - rz);
    end
    o.out_quat_w = nw[31:0];
    o.out_quat_x = nx[31:0];
    o.out_quat_y = ny[31:0];
    o.out_quat_z = nz[31:0];
    return o;
  endfunction

  function automatic logic [31:0] rand_unit();
    return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
  endfunction

  function automatic logic [31:0] rand_pos_field();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(32'h0020_0000, 0) - 32'h0010_0000;
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $signed($urandom) >>> 8;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_quat_field();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1: v = $urandom;
      2, 3: begin
        case ($urandom_range(4))
          0: v = 32'h4000_0000;
          1: v = 32'hc000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = rand_unit();
    endcase
    return v;
  endfunction

  function automatic pet_pkg::pose_in_t rand_pose();
    pet_pkg::pose_in_t p;
    p.pos_x  = rand_pos_field();
    p.pos_y  = rand_pos_field();
    p.pos_z  = rand_pos_field();
    p.quat_w = rand_quat_field();
    p.quat_x = rand_quat_field();
    p.quat_y = rand_quat_field();
    p.quat_z = rand_quat_field();
    return p;
  endfunction

  function automatic pet_pkg::pose_in_t make_pose(input logic [31:0] px,
                                                  input logic [31:0] py,
                                                  input logic [31:0] pz,
                                                  input logic [31:0] qw,
                                                  input logic [31:0] qx,
                                                  input logic [31:0] qy,
                                                  input logic [31:0] qz);
    pet_pkg::pose_in_t p;
    p.pos_x  = px;
    p.pos_y  = py;
    p.pos_z  = pz;
    p.quat_w = qw;
    p.quat_x = qx;
    p.quat_y = qy;
    p.quat_z = qz;
    return p;
  endfunction

  // one pose beat; expectation is pushed once the beat is taken
  task automatic send_pose(input pet_pkg::pose_in_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    pose_in <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_poses.push_back(predict_pose(p));
    poses_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pet_pkg::IndexW-1:0] index,
                           input logic [pet_pkg::DataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (index)
      pet_pkg::REG_OFFSET_X:     ext_off_x = longint'(signed'(data));
      pet_pkg::REG_OFFSET_Y:     ext_off_y = longint'(signed'(data));
      pet_pkg::REG_OFFSET_Z:     ext_off_z = longint'(signed'(data));
      pet_pkg::REG_ROT_COS_HALF: ext_cos   = longint'(signed'(data));
      pet_pkg::REG_ROT_SIN_HALF: ext_sin   = longint'(signed'(data));
      pet_pkg::REG_DIRECTION:    ext_dir   = data[0];
      default: ;
    endcase
  endtask

  task automatic write_extrinsic(input logic [31:0] ox, input logic [31:0] oy,
                                 input logic [31:0] oz, input logic [31:0] c,
                                 input logic [31:0] s, input logic [31:0] dir);
    drain_results();
    write_reg(pet_pkg::REG_OFFSET_X, ox);
    write_reg(pet_pkg::REG_OFFSET_Y, oy);
    write_reg(pet_pkg::REG_OFFSET_Z, oz);
    write_reg(pet_pkg::REG_ROT_COS_HALF, c);
    write_reg(pet_pkg::REG_ROT_SIN_HALF, s);
    write_reg(pet_pkg::REG_DIRECTION, dir);
  endtask

  task automatic test_identity_after_reset();
    idle_pct = 0;
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h4000_0000, 0, 0, 0));
    send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'hc000_0000, 0, 0, 0));
    send_pose(make_pose(32'hffff_ffff, 1, 0, 0, 32'h4000_0000, 0, 0));
    send_pose(make_pose(1, 32'hffff_ffff, 0, 0, 0, 32'h4000_0000, 0));
    send_pose(make_pose(0, 0, 32'hffff_ffff, 0, 0, 0, 32'h4000_0000));
    send_pose(make_pose(0, 0, 0, 32'hc000_0000, 32'hc000_0000, 32'hc000_0000,
                        32'hc000_0000));
    // quaternion parts beyond +-1.0 get clamped before use
    send_pose(make_pose(32'h0001_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                        32'h4000_0001, 32'hbfff_ffff));
  endtask

  task automatic test_extreme_extrinsics();
    idle_pct = 0;
    // big offset, non-unit rotation, forward: pushes positions into saturation
    write_extrinsic(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h4000_0000, 32'h4000_0000, 32'(pet_pkg::DIR_FORWARD));
    send_pose(make_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
    send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'hc000_0000, 32'h4000_0000, 32'hc000_0000, 32'h4000_0000));
    send_pose(make_pose(0, 0, 0, 32'h2d41_3ccd, 0, 0, 32'h2d41_3ccd));
    write_extrinsic(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'hc000_0000, 32'hc000_0000, 32'(pet_pkg::DIR_INVERSE));
    send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h4000_0000, 32'hc000_0000, 32'h4000_0000, 32'hc000_0000));
    send_pose(make_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
    // rotation registers outside +-1.0, direction from bit 0 only
    write_extrinsic(32'h0003_0000, 32'hfffe_0000, 32'h0001_8000,
                    32'h7fff_ffff, 32'h8000_0000, 32'hffff_fffe);
    send_pose(make_pose(32'h0010_0000, 32'hfff0_0000, 0,
                        32'h4000_0000, 0, 0, 0));
    send_pose(make_pose(0, 0, 0, 32'h2000_0000, 32'h2000_0000,
                        32'h2000_0000, 32'h2000_0000));
    drain_results();
    write_reg(pet_pkg::REG_DIRECTION, 32'h8000_0001);
    send_pose(make_pose(0, 0, 0, 32'h4000_0000, 0, 0, 0));
    send_pose(make_pose(32'h1234_5678, 32'hedcb_a988, 32'h0000_ffff,
                        32'h3000_0000, 32'hf000_0000, 32'h1000_0000, 32'hd000_0000));
    // indexes past the last register must leave the extrinsic alone
    drain_results();
    write_reg(3'd6, 32'hdead_beef);
    write_reg(3'd7, 32'h0bad_f00d);
    send_pose(make_pose(0, 0, 0, 32'h4000_0000, 0, 0, 0));
    send_pose(make_pose(32'hffff_0000, 32'h0001_0000, 32'h0000_8000,
                        32'h4000_0000, 0, 0, 0));
  endtask

  task automatic randomize_extrinsic();
    logic [31:0] o [3];
    logic [31:0] c, s;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: o[i] = $urandom;
        1: o[i] = ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
        default: o[i] = $urandom_range(32'h000a_0000, 0) - 32'h0005_0000;
      endcase
    end
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: begin c = 32'h4000_0000; s = 0; end
          1: begin c = 0; s = 32'h4000_0000; end
          2: begin c = 32'h2d41_3ccd; s = 32'hd2be_c333; end
          default: begin c = 32'hc000_0000; s = 0; end
        endcase
      end
      1: begin c = $urandom; s = $urandom; end
      default: begin c = rand_unit(); s = rand_unit(); end
    endcase
    write_extrinsic(o[0], o[1], o[2], c, s, $urandom);
  endtask

  task automatic test_random_phase(input int n_poses, input int gap_pct,
                                   input bit pause_midway);
    randomize_extrinsic();
    idle_pct = gap_pct;
    for (int i = 0; i < n_poses; i++) begin
      send_pose(rand_pose());
      // let the pipe run dry once before carrying on
      if (pause_midway && i == n_poses / 2) drain_results();
    end
  endtask

  // result check: every done beat against the oldest expectation
  always @(posedge clk) begin : check_results
    pet_pkg::pose_out_t want;
    logic [223:0] want_bits;
    logic [223:0] got_bits;
    int           fi;
    if (!rst && done) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no pose outstanding, expected none actual %h",
                 $time, result);
      end else begin
        want      = pending_poses.pop_front();
        want_bits = want;
        got_bits  = result;
        poses_checked++;
        for (fi = 0; fi < 7; fi++) begin
          if (want_bits[223 - 32 * fi -: 32] !== got_bits[223 - 32 * fi -: 32]) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, field_name[fi],
                     want_bits[223 - 32 * fi -: 32], got_bits[223 - 32 * fi -: 32]);
          end
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    pose_in       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    ext_off_x     = 0;
    ext_off_y     = 0;
    ext_off_z     = 0;
    ext_cos       = longint'(1) <<< 30;
    ext_sin       = 0;
    ext_dir       = pet_pkg::DIR_INVERSE;
    idle_pct      = 0;
    poses_sent    = 0;
    poses_checked = 0;
    mismatches    = 0;
    reg_writes    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_after_reset();
    test_extreme_extrinsics();
    test_random_phase(90, 0, 1'b0);
    test_random_phase(90, 67, 1'b1);
    test_random_phase(90, 38, 1'b0);
    test_random_phase(90, 0, 1'b1);
    test_random_phase(90, 67, 1'b0);
    test_random_phase(90, 38, 1'b0);

    drain_results();
    repeat (16) @(posedge clk);
    $display("sent %0d poses across reset, extreme and random extrinsics (%0d reg writes)",
             poses_sent, reg_writes);
    $display("checked %0d output poses at sender gap rates 0/38/67%%, %0d field errors",
             poses_checked, mismatches);
    if (mismatches == 0 && pending_poses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pet_pkg.sv
hdl/pet_quat_mul.sv
hdl/pet_rotate.sv
hdl/pose_extrinsic_transform.sv
test/pose_extrinsic_transform_tb.sv
